// ===== sv/http_chunked_body_decoder_top_defines.svh =====
// Assertion macros for the chunked body decoder.
// Included by the top level; no other dependencies.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HCBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HCBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hcbd_pkg.sv =====
// Shared types, codes and character helpers for the chunked body decoder.
// No dependencies.
package hcbd_pkg;

  // Default width of the chunk size counter
  localparam int SIZE_BITS_DEF = 32;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NO_LINE_END = 3'd0;
  localparam logic [2:0] ERR_NO_DIGITS   = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd2;
  localparam logic [2:0] ERR_TRAILER     = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd4;
  localparam logic [2:0] ERR_SEPARATOR   = 3'd5;

  // Characters of interest
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  // One result transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] code;
    logic [7:0] data;
  } res_t;

  // ASCII hex digit test
  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Hex digit value, valid only when is_hex holds
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// ===== sv/http_chunked_body_decoder_top.sv =====
// Results are registered (in the skid register while the output stalls).
// Throughput: one input byte per cycle while the skid register is empty; the parser
// state updates in the cycle of acceptance, and a one-entry skid register behind
// the result register keeps in_tready high while one result waits for out_tready.
// Reset: synchronous, active low; parser returns to size-line parsing, buffers empty.
// Depends on hcbd_pkg and http_chunked_body_decoder_top_defines.svh.
`include "http_chunked_body_decoder_top_defines.svh"

module http_chunked_body_decoder_top
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] body_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_out, [10:8] err_code, [15:11] zero
  output logic [1:0]  out_tuser   // [1:0] result_kind
);

  typedef enum logic [2:0] {
    PH_SIZE, PH_DATA, PH_SEP_CR, PH_SEP_LF, PH_TRAILER, PH_DONE, PH_HALT
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   bytes_r, bytes_nxt;
  logic                   saw_r, saw_nxt;
  logic                   closed_r, closed_nxt;
  logic                   ext_r, ext_nxt;
  logic                   pend_r, pend_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   in_acc;
  logic                   res_vld;
  res_t                   res;
  logic                   out_valid_r, skid_valid_r;
  res_t                   out_r, skid_r;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  // Parser next state and result
  always_comb begin
    phase_nxt  = phase_r;
    bytes_nxt  = bytes_r;
    saw_nxt    = saw_r;
    closed_nxt = closed_r;
    ext_nxt    = ext_r;
    pend_nxt   = pend_r;
    ovf_nxt    = ovf_r;
    res_vld    = 1'b0;
    res.kind   = KIND_DATA;
    res.code   = ERR_NO_LINE_END;
    res.data   = '0;
    if (in_acc) begin
      unique case (phase_r)
        PH_SIZE: begin
          if (pend_r && in_tdata == CHAR_LF) begin
            // line end
            saw_nxt    = 1'b0;
            closed_nxt = 1'b0;
            ext_nxt    = 1'b0;
            pend_nxt   = 1'b0;
            ovf_nxt    = 1'b0;
            if (!saw_r) begin
              res_vld   = 1'b1;
              res.kind  = KIND_ERR;
              res.code  = ERR_NO_DIGITS;
              phase_nxt = PH_HALT;
            end else if (ovf_r) begin
              res_vld   = 1'b1;
              res.kind  = KIND_ERR;
              res.code  = ERR_OVERFLOW;
              phase_nxt = PH_HALT;
            end else if (bytes_r == '0) begin
              phase_nxt = PH_TRAILER;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            // lone CR acts as whitespace: closes digits once any were seen
            if (pend_r && !ext_r && !closed_r && saw_r) begin
              closed_nxt = 1'b1;
            end
            pend_nxt = 1'b0;
            if (in_tdata == CHAR_CR) begin
              pend_nxt = 1'b1;
            end else if (!ext_nxt) begin
              if (in_tdata == CHAR_SEMI) begin
                ext_nxt = 1'b1;
              end else if (!closed_nxt) begin
                if (is_hex(in_tdata)) begin
                  saw_nxt = 1'b1;
                  if (!ovf_r) begin
                    if (bytes_r[SIZE_BITS-1:SIZE_BITS-4] != 4'd0) begin
                      ovf_nxt = 1'b1;
                    end else begin
                      bytes_nxt = {bytes_r[SIZE_BITS-5:0], hex_val(in_tdata)};
                    end
                  end
                end else if (!(is_space(in_tdata) && !saw_r)) begin
                  closed_nxt = 1'b1;
                end
              end
            end
          end
        end
        PH_DATA: begin
          res_vld  = 1'b1;
          res.kind = KIND_DATA;
          res.data = in_tdata;
          if (bytes_r != '0) begin
            bytes_nxt = bytes_r - SIZE_BITS'(1);
          end
          if (bytes_r <= SIZE_BITS'(1)) begin
            phase_nxt = PH_SEP_CR;
          end
        end
        PH_SEP_CR: begin
          if (in_tdata == CHAR_CR) begin
            phase_nxt = PH_SEP_LF;
          end else begin
            res_vld   = 1'b1;
            res.kind  = KIND_ERR;
            res.code  = in_tlast ? ERR_TRUNCATED : ERR_SEPARATOR;
            phase_nxt = PH_HALT;
          end
        end
        PH_SEP_LF: begin
          if (in_tdata == CHAR_LF) begin
            phase_nxt  = PH_SIZE;
            bytes_nxt  = '0;
            saw_nxt    = 1'b0;
            closed_nxt = 1'b0;
            ext_nxt    = 1'b0;
            pend_nxt   = 1'b0;
            ovf_nxt    = 1'b0;
          end else begin
            res_vld   = 1'b1;
            res.kind  = KIND_ERR;
            res.code  = ERR_SEPARATOR;
            phase_nxt = PH_HALT;
          end
        end
        PH_TRAILER: begin
          if (pend_r && in_tdata == CHAR_LF) begin
            pend_nxt  = 1'b0;
            res_vld   = 1'b1;
            res.kind  = KIND_END;
            phase_nxt = PH_DONE;
          end else begin
            pend_nxt = (in_tdata == CHAR_CR);
          end
        end
        default: begin
          // done or halted: bytes are dropped
        end
      endcase

      // final byte with the body still open
      if (in_tlast && phase_nxt != PH_DONE && phase_nxt != PH_HALT) begin
        res_vld  = 1'b1;
        res.kind = KIND_ERR;
        res.data = '0;
        priority if (phase_nxt == PH_SIZE) begin
          res.code = ERR_NO_LINE_END;
        end else if (phase_nxt == PH_TRAILER) begin
          res.code = ERR_TRAILER;
        end else begin
          res.code = ERR_TRUNCATED;
        end
        phase_nxt = PH_HALT;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE;
      bytes_r  <= '0;
      saw_r    <= 1'b0;
      closed_r <= 1'b0;
      ext_r    <= 1'b0;
      pend_r   <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      bytes_r  <= bytes_nxt;
      saw_r    <= saw_nxt;
      closed_r <= closed_nxt;
      ext_r    <= ext_nxt;
      pend_r   <= pend_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // Result register and skid register: valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Result register and skid register: payload
  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.code, out_r.data};
  assign out_tuser  = out_r.kind;

  // Checks
  `HCBD_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
    "skid register holds a result while the result register is empty")
  `HCBD_ASSERT_NOW(a_data_count_nonzero, phase_r == PH_DATA, bytes_r != '0,
    "data phase entered with a zero byte count")
  `HCBD_ASSERT_NEXT(a_stopped_stays,
    phase_r == PH_DONE || phase_r == PH_HALT, phase_r == $past(phase_r),
    "parser left its terminal phase without reset")

endmodule
